>>> src/gbft_pkg.sv
// Shared types and constants for the graph breadth-first traversal unit.
// Depends on nothing; used by graph_breadth_first_traversal_unit.
`default_nettype none

package gbft_pkg;

  localparam int MaxVerticesDef = 16;

  localparam int KindW      = 1;
  localparam int RowIndexW  = 4;
  localparam int RowBitsW   = 16;
  localparam int VertexW    = 4;
  localparam int ComponentW = 4;
  localparam int CountW     = 5;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  localparam logic       RegVertexCount = 1'b0;
  localparam logic [4:0] VertexCountRst = 5'd16;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindStart = 1'b1;

  typedef struct packed {
    logic [KindW-1:0]     kind;
    logic [RowIndexW-1:0] row_index;
    logic [RowBitsW-1:0]  row_bits;
    logic [VertexW-1:0]   start_vertex;
  } in_t;

  typedef struct packed {
    logic [VertexW-1:0]    vertex;
    logic [ComponentW-1:0] component;
    logic                  last;
    logic [CountW-1:0]     component_count;
  } out_t;

endpackage

`default_nettype wire

>>> src/gbft_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the adjacency rows and the vertex queue of the traversal unit.
`default_nettype none

module gbft_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/graph_breadth_first_traversal_unit.sv
// Top level of the graph breadth-first traversal unit: sequencer, marks, control.
// Depends on gbft_pkg and gbft_ram (adjacency rows and vertex queue).
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes two kinds of transaction.
// A load writes one adjacency row. A start clears the visited marks and walks
// every vertex below vertex_count, capped at MaxVertices: first from the source,
// then from each unvisited vertex in index order, one component each.
// Every vertex leaves on the output channel (out_valid_o/out_ready_i/out_data_o)
// once, in breadth-first order; the final one carries last and the count.
// A start keeps in_ready_o low until the walk ends, with seed steps between
// components: each dequeued vertex takes a queue read, a row fetch, an emit
// and a scan of all n rows, one row a cycle through the single read port of
// the adjacency RAM. When the source is in range, the first transaction passes
// the StDeq, StFetch and StEmit states and leaves from the result register.
// A stalled output holds the sequencer at its next emit; the result register
// keeps its transaction until taken. Reset clears control state and sets
// vertex_count to 16; rows read before being loaded give undefined edges.
// vertex_count is written over the APB port at address 0; the user must do so only while idle (unenforced).
`default_nettype none

module graph_breadth_first_traversal_unit #(
  parameter int MaxVertices = gbft_pkg::MaxVerticesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gbft_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gbft_pkg::out_t                     out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbft_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [gbft_pkg::CfgDataW-1:0] pwdata,
  output logic      [gbft_pkg::CfgDataW-1:0] prdata,
  output logic                               pready
);

  localparam int VW = $clog2(MaxVertices);
  localparam int NW = $clog2(MaxVertices + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSeed  = 3'd1;
  localparam logic [2:0] StDeq   = 3'd2;
  localparam logic [2:0] StEmit  = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StFetch = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [4:0]             vc_q;
  logic [NW-1:0]          n_q, n_d;
  logic [MaxVertices-1:0] visited_q, visited_d;
  logic [NW-1:0]          head_q, head_d;
  logic [NW-1:0]          tail_q, tail_d, tail_base;
  logic [NW-1:0]          comp_q, comp_d;
  logic [NW-1:0]          emit_cnt_q, emit_cnt_d;
  logic [VW-1:0]          seed_q, seed_d;
  logic [VW-1:0]          m_q, m_d;
  logic [VW-1:0]          i_q, i_d;
  logic [MaxVertices-1:0] row_m_q;
  logic                   out_valid_q, out_valid_d;
  gbft_pkg::out_t         out_q;

  logic                   in_fire, start, out_free, emit_fire;
  logic                   enq_en;
  logic [VW-1:0]          enq_vtx;
  logic                   edge_hit, scan_end;
  logic                   ram_we, ram_re;
  logic [VW-1:0]          ram_raddr;
  logic [MaxVertices-1:0] ram_rdata;
  logic                   q_re;
  logic [VW-1:0]          q_rdata;
  logic                   cfg_wr;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign start      = in_fire && (in_data_i.kind == gbft_pkg::KindStart);
  assign ram_we     = in_fire && (in_data_i.kind == gbft_pkg::KindLoad) &&
                      (32'(in_data_i.row_index) < MaxVertices);
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == StEmit) && out_free;
  assign edge_hit   = !visited_q[i_q] && (row_m_q[i_q] || ram_rdata[m_q]);
  assign scan_end   = (NW'(i_q) == n_q - NW'(1));
  assign tail_base  = start ? '0 : tail_q;

  gbft_ram #(
    .Width(MaxVertices),
    .Depth(MaxVertices)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(VW'(in_data_i.row_index)),
    .wdata_i(MaxVertices'(in_data_i.row_bits)),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gbft_ram #(
    .Width(VW),
    .Depth(MaxVertices)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (enq_en),
    .waddr_i(tail_base[VW-1:0]),
    .wdata_i(enq_vtx),
    .re_i   (q_re),
    .raddr_i(head_q[VW-1:0]),
    .rdata_o(q_rdata)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    head_d      = head_q;
    comp_d      = comp_q;
    emit_cnt_d  = emit_cnt_q;
    seed_d      = seed_q;
    m_d         = m_q;
    i_d         = i_q;
    enq_en      = 1'b0;
    enq_vtx     = seed_q;
    ram_re      = 1'b0;
    ram_raddr   = i_q;
    q_re        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (32'(vc_q) > MaxVertices) begin
            n_d = NW'(MaxVertices);
          end else begin
            n_d = NW'(vc_q);
          end
          head_d     = '0;
          comp_d     = '0;
          emit_cnt_d = '0;
          seed_d     = '0;
          if (n_d != '0) begin
            if (32'(in_data_i.start_vertex) < 32'(n_d)) begin
              enq_en  = 1'b1;
              enq_vtx = VW'(in_data_i.start_vertex);
              state_d = StDeq;
            end else begin
              state_d = StSeed;
            end
          end
        end
      end
      StSeed: begin
        if (!visited_q[seed_q]) begin
          enq_en  = 1'b1;
          enq_vtx = seed_q;
          state_d = StDeq;
        end else begin
          seed_d = seed_q + VW'(1);
        end
      end
      StDeq: begin
        q_re    = 1'b1;
        head_d  = head_q + NW'(1);
        state_d = StFetch;
      end
      StFetch: begin
        m_d       = q_rdata;
        ram_re    = 1'b1;
        ram_raddr = m_d;
        state_d   = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          emit_cnt_d  = emit_cnt_q + NW'(1);
          ram_re      = 1'b1;
          ram_raddr   = '0;
          i_d         = '0;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (edge_hit) begin
          enq_en  = 1'b1;
          enq_vtx = i_q;
        end
        if (scan_end) begin
          if (head_q == (enq_en ? tail_q + NW'(1) : tail_q)) begin
            comp_d  = comp_q + NW'(1);
            state_d = (emit_cnt_q == n_q) ? StIdle : StSeed;
          end else begin
            state_d = StDeq;
          end
        end else begin
          i_d       = i_q + VW'(1);
          ram_re    = 1'b1;
          ram_raddr = i_d;
        end
      end
      default: state_d = StIdle;
    endcase

    visited_d = start ? '0 : visited_q;
    tail_d    = tail_base;
    if (enq_en) begin
      visited_d[enq_vtx] = 1'b1;
      tail_d             = tail_base + NW'(1);
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vc_q        <= gbft_pkg::VertexCountRst;
      n_q         <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      comp_q      <= '0;
      emit_cnt_q  <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      visited_q   <= visited_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      comp_q      <= comp_d;
      emit_cnt_q  <= emit_cnt_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        unique case (paddr[2])
          gbft_pkg::RegVertexCount: vc_q <= pwdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    i_q <= i_d;
    if (emit_fire) begin
      row_m_q                   <= ram_rdata;
      out_q.vertex              <= gbft_pkg::VertexW'(m_q);
      out_q.component           <= gbft_pkg::ComponentW'(comp_q);
      out_q.last                <= (emit_cnt_q == n_q - NW'(1));
      out_q.component_count     <= (emit_cnt_q == n_q - NW'(1)) ?
                                   gbft_pkg::CountW'(comp_q + NW'(1)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      gbft_pkg::RegVertexCount: prdata = gbft_pkg::CfgDataW'(vc_q);
      default: ;
    endcase
  end

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= n_q)
    else $error("more vertices emitted than in use");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (NW'(i_q) < n_q))
    else $error("row scan beyond vertex count");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire && (emit_cnt_q == n_q - NW'(1)) |=> (tail_q == n_q))
    else $error("final vertex emitted with vertices left unqueued");

endmodule

`default_nettype wire
